// ----- rtl/core/lpmd_pkg.sv -----
// shared types, constants and the pattern-to-character table for the light pulse morse decoder
// no dependencies; imported by light_pulse_morse_decoder_core
package lpmd_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int TICK_W      = 10;
   localparam int MS_W        = 16;
   localparam int THR_W       = 8;
   localparam int PROD_W      = COUNT_WIDTH + TICK_W;
   localparam int SYM_MAX     = 5;
   localparam int CNT_W       = 3;
   localparam int ADDR_W      = 5;
   localparam int DATA_W      = 32;

   localparam logic [CNT_W-1:0] SYM_OVER = CNT_W'(SYM_MAX + 1);

   localparam logic [THR_W-1:0]  THRESHOLD_RST = 8'd240;
   localparam logic [TICK_W-1:0] TICK_RST      = 10'd25;
   localparam logic [MS_W-1:0]   DOT_MIN_RST   = 16'd150;
   localparam logic [MS_W-1:0]   DOT_MAX_RST   = 16'd375;
   localparam logic [MS_W-1:0]   DASH_MIN_RST  = 16'd500;
   localparam logic [MS_W-1:0]   DASH_MAX_RST  = 16'd1000;
   localparam logic [MS_W-1:0]   SPACE_RST     = 16'd800;

   localparam logic [6:0] UNKNOWN_CHAR = 7'("?");

   typedef enum logic [2:0] {
      REG_THRESHOLD = 3'd0,
      REG_TICK      = 3'd1,
      REG_DOT_MIN   = 3'd2,
      REG_DOT_MAX   = 3'd3,
      REG_DASH_MIN  = 3'd4,
      REG_DASH_MAX  = 3'd5,
      REG_SPACE     = 3'd6
   } csr_reg_type;

   typedef enum logic [1:0] {
      EV_NONE = 2'd0,
      EV_DOT  = 2'd1,
      EV_DASH = 2'd2
   } sym_event_type;

   // bit i of bits is symbol i in arrival order, 1 = dash
   function automatic logic [6:0] decode_pattern(input logic [CNT_W-1:0] len,
                                                 input logic [4:0] bits);
      logic [6:0] ch;
      ch = UNKNOWN_CHAR;
      unique case (len)
         3'd1: begin
            unique case (bits[0])
               1'b0: ch = 7'("e");
               1'b1: ch = 7'("t");
               default: ch = UNKNOWN_CHAR;
            endcase
         end
         3'd2: begin
            unique case (bits[1:0])
               2'b10: ch = 7'("a");
               2'b00: ch = 7'("i");
               2'b11: ch = 7'("m");
               2'b01: ch = 7'("n");
               default: ch = UNKNOWN_CHAR;
            endcase
         end
         3'd3: begin
            unique case (bits[2:0])
               3'b001: ch = 7'("d");
               3'b011: ch = 7'("g");
               3'b101: ch = 7'("k");
               3'b111: ch = 7'("o");
               3'b010: ch = 7'("r");
               3'b000: ch = 7'("s");
               3'b100: ch = 7'("u");
               3'b110: ch = 7'("w");
               default: ch = UNKNOWN_CHAR;
            endcase
         end
         3'd4: begin
            unique case (bits[3:0])
               4'b0001: ch = 7'("b");
               4'b0101: ch = 7'("c");
               4'b0100: ch = 7'("f");
               4'b0000: ch = 7'("h");
               4'b1110: ch = 7'("j");
               4'b0010: ch = 7'("l");
               4'b0110: ch = 7'("p");
               4'b1011: ch = 7'("q");
               4'b1000: ch = 7'("v");
               4'b1001: ch = 7'("x");
               4'b1101: ch = 7'("y");
               4'b0011: ch = 7'("z");
               default: ch = UNKNOWN_CHAR;
            endcase
         end
         3'd5: begin
            unique case (bits)
               5'b11111: ch = 7'("0");
               5'b11110: ch = 7'("1");
               5'b11100: ch = 7'("2");
               5'b11000: ch = 7'("3");
               5'b10000: ch = 7'("4");
               5'b00000: ch = 7'("5");
               5'b00001: ch = 7'("6");
               5'b00011: ch = 7'("7");
               5'b00111: ch = 7'("8");
               5'b01111: ch = 7'("9");
               default: ch = UNKNOWN_CHAR;
            endcase
         end
         default: ch = UNKNOWN_CHAR;
      endcase
      return ch;
   endfunction

endpackage

// ----- rtl/core/light_pulse_morse_decoder_core.sv -----
// light pulse morse decoder: sample input register, per-tick decode logic, result register
// depends on lpmd_pkg (constants, register and event codes, character table)
//
// One 8-bit light sample per beat, one result beat per sample. A sample passes from input to
// output through the input register, then the result register. A new sample is taken every
// cycle while results are taken, because the whole per-tick step sits between the two
// registers. That step is one 16x10 multiply plus the range compares, and it sets the clock
// period rather than the rate. A result beat held by rsp_tready low keeps its sample in the
// input register, and req_tready then stays low until that result leaves. Pulse lengths are
// on_ticks * tick_ms, dark time is off_ticks * tick_ms; both counters saturate. Configuration
// registers sit at byte addresses 4*i and must only be written while no sample is in flight.
module light_pulse_morse_decoder_core
   import lpmd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // slave side
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] light_sample
   // master side
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,   // [0] light_on, [2:1] symbol_event, [3] char_valid,
                                          // [10:4] char_code, [15:11] zero
   // configuration
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   // configuration registers
   logic [THR_W-1:0]  thr_ff;
   logic [TICK_W-1:0] tick_ff;
   logic [MS_W-1:0]   dot_min_ff, dot_max_ff, dash_min_ff, dash_max_ff, space_ff;

   csr_reg_type csr_idx;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_reg_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= THRESHOLD_RST;
         tick_ff     <= TICK_RST;
         dot_min_ff  <= DOT_MIN_RST;
         dot_max_ff  <= DOT_MAX_RST;
         dash_min_ff <= DASH_MIN_RST;
         dash_max_ff <= DASH_MAX_RST;
         space_ff    <= SPACE_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_THRESHOLD: thr_ff      <= csr_pwdata[THR_W-1:0];
            REG_TICK:      tick_ff     <= csr_pwdata[TICK_W-1:0];
            REG_DOT_MIN:   dot_min_ff  <= csr_pwdata[MS_W-1:0];
            REG_DOT_MAX:   dot_max_ff  <= csr_pwdata[MS_W-1:0];
            REG_DASH_MIN:  dash_min_ff <= csr_pwdata[MS_W-1:0];
            REG_DASH_MAX:  dash_max_ff <= csr_pwdata[MS_W-1:0];
            REG_SPACE:     space_ff    <= csr_pwdata[MS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_THRESHOLD: csr_prdata = DATA_W'(thr_ff);
         REG_TICK:      csr_prdata = DATA_W'(tick_ff);
         REG_DOT_MIN:   csr_prdata = DATA_W'(dot_min_ff);
         REG_DOT_MAX:   csr_prdata = DATA_W'(dot_max_ff);
         REG_DASH_MIN:  csr_prdata = DATA_W'(dash_min_ff);
         REG_DASH_MAX:  csr_prdata = DATA_W'(dash_max_ff);
         REG_SPACE:     csr_prdata = DATA_W'(space_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // handshake: input register feeds result register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] sample_ff;
   logic       out_vld_ff, out_vld_in;
   logic       out_free, step;

   assign out_free   = ~out_vld_ff | rsp_tready;
   assign step       = in_vld_ff & out_free;
   // no beat is taken while in reset
   assign req_tready = ~reset & (~in_vld_ff | step);
   assign in_vld_in  = (req_tvalid & req_tready) | (in_vld_ff & ~step);
   assign out_vld_in = step | (out_vld_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         sample_ff <= req_tdata;
      end
   end

   // decoder state
   logic                   seen_ff, seen_in;
   logic                   gap_ff, gap_in;
   logic [COUNT_WIDTH-1:0] on_ff, on_in;
   logic [COUNT_WIDTH-1:0] off_ff, off_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [SYM_MAX-1:0]     pat_ff, pat_in;

   logic                   lit;
   logic [COUNT_WIDTH-1:0] on_inc, off_inc, mul_a;
   logic [PROD_W-1:0]      prod;
   logic                   is_dot, is_dash;
   sym_event_type          ev;
   logic                   cvalid;
   logic [6:0]             ccode;

   assign lit     = sample_ff < thr_ff;
   assign on_inc  = (on_ff == '1) ? on_ff : on_ff + COUNT_WIDTH'(1);
   assign off_inc = (off_ff == '1) ? off_ff : off_ff + COUNT_WIDTH'(1);

   // one shared multiplier: pulse length while a pulse ends, dark time otherwise
   assign mul_a = seen_ff ? on_ff : off_inc;
   assign prod  = PROD_W'(mul_a) * PROD_W'(tick_ff);

   assign is_dot  = (prod >= PROD_W'(dot_min_ff)) && (prod <= PROD_W'(dot_max_ff));
   assign is_dash = (prod >= PROD_W'(dash_min_ff)) && (prod <= PROD_W'(dash_max_ff));

   always_comb begin
      seen_in = seen_ff;
      gap_in  = gap_ff;
      on_in   = on_ff;
      off_in  = off_ff;
      cnt_in  = cnt_ff;
      pat_in  = pat_ff;
      ev      = EV_NONE;
      cvalid  = 1'b0;
      ccode   = '0;
      priority if (lit) begin
         if (!seen_ff) begin
            seen_in = 1'b1;
         end else begin
            on_in = on_inc;
         end
      end else if (seen_ff) begin
         // pulse has ended
         seen_in = 1'b0;
         gap_in  = 1'b1;
         off_in  = '0;
         on_in   = '0;
         priority if (is_dot) begin
            ev = EV_DOT;
         end else if (is_dash) begin
            ev = EV_DASH;
         end else begin
            ev = EV_NONE;
         end
         if (ev != EV_NONE) begin
            if (cnt_ff < CNT_W'(SYM_MAX)) begin
               if (ev == EV_DASH) begin
                  pat_in = pat_ff | (SYM_MAX'(1) << cnt_ff);
               end
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               cnt_in = SYM_OVER;
            end
         end
      end else if (gap_ff) begin
         off_in = off_inc;
         if (prod >= PROD_W'(space_ff)) begin
            if (cnt_ff != '0) begin
               cvalid = 1'b1;
               ccode  = decode_pattern(cnt_ff, pat_ff);
            end
            cnt_in = '0;
            pat_in = '0;
            off_in = '0;
            gap_in = 1'b0;
         end
      end else begin
         seen_in = seen_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         gap_ff  <= 1'b0;
         on_ff   <= '0;
         off_ff  <= '0;
         cnt_ff  <= '0;
         pat_ff  <= '0;
      end else if (step) begin
         seen_ff <= seen_in;
         gap_ff  <= gap_in;
         on_ff   <= on_in;
         off_ff  <= off_in;
         cnt_ff  <= cnt_in;
         pat_ff  <= pat_in;
      end
   end

   // result register
   logic [15:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (step) begin
         rdata_ff <= {5'd0, ccode, cvalid, ev, lit};
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = rdata_ff;

   // checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= SYM_OVER)
      else $error("symbol count beyond overflow mark");

   a_char_not_with_symbol: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> !(rdata_ff[3] && (rdata_ff[2:1] != EV_NONE)))
      else $error("character and symbol in the same beat");

   a_char_code_set: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && rdata_ff[3]) |-> (rdata_ff[10:4] != 7'd0))
      else $error("decoded character has null code");

   a_lit_no_event: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && rdata_ff[0]) |-> (rdata_ff[2:1] == EV_NONE) && !rdata_ff[3])
      else $error("event reported on a lit sample");

   a_state_only_on_step: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(cnt_ff) && $stable(pat_ff) && $stable(seen_ff))
      else $error("decoder state moved without a sample");

endmodule
